FILE: hdl/lfucs_pkg.sv
// Shared constants, codes and types for the LFU key/value store.
package lfucs_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_W          = 5;
    localparam int KEY_W          = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    localparam logic signed [KEY_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_UPD,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_TOUCH,
        OP_INSERT
    } t_op;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [KEY_W-1:0] read_value;
    } t_res;

endpackage

FILE: hdl/lfucs_engine.sv
// Entry storage and sequencer: search pass, optional read-modify-write pass.
module lfucs_engine #(
    parameter int ENTRIES    = lfucs_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfucs_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  lfucs_pkg::t_req               i_req,
    input  logic [lfucs_pkg::CAP_W-1:0]   i_cap,
    output logic                          o_busy,
    output logic                          o_res_valid,
    output lfucs_pkg::t_res               o_res,
    input  logic                          i_res_take
);
    import lfucs_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL_USED = CW'(ENTRIES);

    typedef struct packed {
        logic                  hit;
        logic [IW-1:0]         hit_idx;
        logic [IW-1:0]         hit_rank;
        logic [KEY_W-1:0]      hit_data;
        logic                  vic_found;
        logic [IW-1:0]         vic_idx;
        logic [COUNT_BITS-1:0] vic_cnt;
        logic [IW-1:0]         vic_rank;
        logic                  free_found;
        logic [IW-1:0]         free_idx;
        logic [CW-1:0]         used;
    } t_scan;

    // entry storage
    logic [KEY_W-1:0]      r_key_mem  [ENTRIES];
    logic [KEY_W-1:0]      r_data_mem [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt_mem  [ENTRIES];
    logic [IW-1:0]         r_rank_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_vld;

    // registered read port
    logic [KEY_W-1:0]      r_q_key;
    logic [KEY_W-1:0]      r_q_data;
    logic [COUNT_BITS-1:0] r_q_cnt;
    logic [IW-1:0]         r_q_rank;

    t_state        r_state, n_state;
    logic          r_issue, n_issue;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_chk, n_chk;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic          r_chk_last, n_chk_last;
    t_req          r_req, n_req;
    t_scan         r_scan, n_scan;
    t_op           r_op, n_op;
    logic [IW-1:0] r_tgt_idx, n_tgt_idx;
    logic [IW-1:0] r_tgt_rank, n_tgt_rank;
    logic          r_evict, n_evict;

    logic                  w_we_key, w_we_data, w_we_cnt, w_we_rank, w_set_vld;
    logic [KEY_W-1:0]      w_key, w_data;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [IW-1:0]         w_rank;

    logic                  e_vld, e_match, e_better, full;
    logic [COUNT_BITS-1:0] e_cnt_inc;

    assign e_vld     = r_vld[r_chk_idx];
    assign e_match   = e_vld && (r_q_key == r_req.key);
    // the shared compare: lowest count, then oldest among equal counts
    assign e_better  = e_vld && (!r_scan.vic_found || (r_q_cnt < r_scan.vic_cnt) ||
                       ((r_q_cnt == r_scan.vic_cnt) && (r_q_rank > r_scan.vic_rank)));
    assign e_cnt_inc = (r_q_cnt == '1) ? r_q_cnt : r_q_cnt + COUNT_BITS'(1);
    assign full      = (LW'(n_scan.used) >= LW'(i_cap)) || (n_scan.used == FULL_USED);

    always_comb begin
        n_state    = r_state;
        n_issue    = 1'b0;
        n_idx      = r_idx;
        n_chk      = 1'b0;
        n_chk_idx  = r_chk_idx;
        n_chk_last = r_chk_last;
        n_req      = r_req;
        n_scan     = r_scan;
        n_op       = r_op;
        n_tgt_idx  = r_tgt_idx;
        n_tgt_rank = r_tgt_rank;
        n_evict    = r_evict;
        w_we_key   = 1'b0;
        w_we_data  = 1'b0;
        w_we_cnt   = 1'b0;
        w_we_rank  = 1'b0;
        w_set_vld  = 1'b0;
        w_key      = r_req.key;
        w_data     = r_req.value;
        w_cnt      = e_cnt_inc;
        w_rank     = '0;

        // address walk shared by both passes
        if ((r_state == S_SRCH || r_state == S_UPD) && r_issue) begin
            n_chk      = 1'b1;
            n_chk_idx  = r_idx;
            n_chk_last = (r_idx == LAST_IDX);
            if (r_idx != LAST_IDX) begin
                n_issue = 1'b1;
                n_idx   = r_idx + IW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SRCH;
                    n_req   = i_req;
                    n_issue = 1'b1;
                    n_idx   = '0;
                    n_scan  = '0;
                end
            end
            S_SRCH: begin
                if (r_chk) begin
                    if (e_vld) begin
                        n_scan.used = r_scan.used + CW'(1);
                    end
                    if (e_match && !r_scan.hit) begin
                        n_scan.hit      = 1'b1;
                        n_scan.hit_idx  = r_chk_idx;
                        n_scan.hit_rank = r_q_rank;
                        n_scan.hit_data = r_q_data;
                    end
                    if (e_better) begin
                        n_scan.vic_found = 1'b1;
                        n_scan.vic_idx   = r_chk_idx;
                        n_scan.vic_cnt   = r_q_cnt;
                        n_scan.vic_rank  = r_q_rank;
                    end
                    if (!e_vld && !r_scan.free_found) begin
                        n_scan.free_found = 1'b1;
                        n_scan.free_idx   = r_chk_idx;
                    end
                    if (r_chk_last) begin
                        n_idx      = '0;
                        n_op       = OP_TOUCH;
                        n_tgt_idx  = n_scan.hit_idx;
                        n_tgt_rank = n_scan.hit_rank;
                        n_evict    = 1'b0;
                        if (r_req.mode == MODE_GET) begin
                            if (n_scan.hit) begin
                                n_state = S_UPD;
                                n_issue = 1'b1;
                            end else begin
                                n_state = S_DONE;
                            end
                        end else if (i_cap == '0) begin
                            n_state = S_IDLE;
                        end else if (n_scan.hit) begin
                            n_state = S_UPD;
                            n_issue = 1'b1;
                        end else if (full) begin
                            n_state    = S_UPD;
                            n_issue    = 1'b1;
                            n_op       = OP_INSERT;
                            n_evict    = 1'b1;
                            n_tgt_idx  = n_scan.vic_idx;
                            n_tgt_rank = n_scan.vic_rank;
                        end else begin
                            n_state   = S_UPD;
                            n_issue   = 1'b1;
                            n_op      = OP_INSERT;
                            n_tgt_idx = n_scan.free_idx;
                        end
                    end
                end
            end
            S_UPD: begin
                if (r_chk) begin
                    if (r_op == OP_TOUCH) begin
                        if (r_chk_idx == r_tgt_idx) begin
                            w_we_rank = 1'b1;
                            w_we_cnt  = 1'b1;
                            w_we_data = (r_req.mode == MODE_SET);
                        end else if (e_vld && (r_q_rank < r_tgt_rank)) begin
                            w_we_rank = 1'b1;
                            w_rank    = r_q_rank + IW'(1);
                        end
                    end else begin
                        if (r_chk_idx == r_tgt_idx) begin
                            w_set_vld = 1'b1;
                            w_we_key  = 1'b1;
                            w_we_data = 1'b1;
                            w_we_cnt  = 1'b1;
                            w_cnt     = COUNT_BITS'(1);
                            w_we_rank = 1'b1;
                        end else if (e_vld) begin
                            // close the gap left by the victim, then age by one
                            w_we_rank = 1'b1;
                            w_rank    = r_q_rank + IW'(1) -
                                ((r_evict && (r_q_rank > r_tgt_rank)) ? IW'(1) : IW'(0));
                        end
                    end
                    if (r_chk_last) begin
                        n_state = (r_req.mode == MODE_GET) ? S_DONE : S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= 1'b0;
            r_chk      <= 1'b0;
            r_chk_last <= 1'b0;
            r_scan     <= '0;
            r_vld      <= '0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_chk      <= n_chk;
            r_chk_last <= n_chk_last;
            r_scan     <= n_scan;
            if (w_set_vld) begin
                r_vld[r_chk_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_req      <= n_req;
        r_op       <= n_op;
        r_tgt_idx  <= n_tgt_idx;
        r_tgt_rank <= n_tgt_rank;
        r_evict    <= n_evict;
    end

    always_ff @(posedge i_clk) begin
        r_q_key  <= r_key_mem[r_idx];
        r_q_data <= r_data_mem[r_idx];
        r_q_cnt  <= r_cnt_mem[r_idx];
        r_q_rank <= r_rank_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_key) begin
            r_key_mem[r_chk_idx] <= w_key;
        end
        if (w_we_data) begin
            r_data_mem[r_chk_idx] <= w_data;
        end
        if (w_we_cnt) begin
            r_cnt_mem[r_chk_idx] <= w_cnt;
        end
        if (w_we_rank) begin
            r_rank_mem[r_chk_idx] <= w_rank;
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.hit        = r_scan.hit;
    assign o_res.read_value = r_scan.hit ? $signed(r_scan.hit_data) : MISS_VALUE;

    a_start_srch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state == S_SRCH))
        else $error("start did not enter search pass");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) >= $countones($past(r_vld)))
        else $error("occupancy dropped");

    a_touch_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_op == OP_TOUCH) |-> r_scan.hit)
        else $error("touch pass without a hit");

    a_res_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_req.mode == MODE_GET))
        else $error("result word for a set");

endmodule

FILE: hdl/lfu_cache_store_core.sv
// LFU key/value store top level: channels, capacity register, output register.
//
// Input channel: i_valid / o_stall with i_mode, i_key, i_value. A get (mode 0)
// returns one word on the output channel (o_valid / i_stall, o_hit, o_read_value);
// a set (mode 1) returns nothing. A miss returns o_hit low and all-ones data.
// The user writes the capacity register through i_cfg_we / i_cfg_wdata only while
// idle; the block itself does not enforce this. Each word is handled by passes over the
// entry memories, one entry per cycle: a search pass (match, occupancy,
// least-frequently-used victim via one shared compare) and, unless a get misses
// or a set meets capacity zero, a read-modify-write pass that updates counts and ranks.
// o_stall is high from the time a word is taken until the engine is idle again; a get
// result is passed to the output register once its passes end. The pace is set by
// the entry memories, which have one registered read port and one write port.
// The result lands in an output register, so a new word is taken while the
// previous result waits; if that register is still held by i_stall when the
// next result is ready, the engine waits and o_stall stays high.
// Reset marks all entries empty and loads capacity 16.
module lfu_cache_store_core #(
    parameter int ENTRIES    = lfucs_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfucs_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lfucs_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic signed [lfucs_pkg::KEY_W-1:0]  i_key,
    input  logic signed [lfucs_pkg::KEY_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic signed [lfucs_pkg::KEY_W-1:0]  o_read_value
);
    import lfucs_pkg::*;

    logic [CAP_W-1:0]        r_cap;
    logic                    r_ovalid;
    logic                    r_ohit;
    logic signed [KEY_W-1:0] r_oval;

    logic   eng_busy, eng_res_valid, take, start;
    t_req   req;
    t_res   res;

    assign start     = i_valid && !eng_busy;
    assign req.mode  = i_mode;
    assign req.key   = i_key;
    assign req.value = i_value;
    assign take      = eng_res_valid && (!r_ovalid || !i_stall);

    lfucs_engine #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_cap       (r_cap),
        .o_busy      (eng_busy),
        .o_res_valid (eng_res_valid),
        .o_res       (res),
        .i_res_take  (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (take) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ohit <= res.hit;
            r_oval <= res.read_value;
        end
    end

    assign o_stall      = eng_busy;
    assign o_valid      = r_ovalid;
    assign o_hit        = r_ohit;
    assign o_read_value = r_oval;

endmodule

FILE: tb/tb_lfu_cache_store_core.sv
// Self-checking testbench for the LFU key/value store core.
module tb_lfu_cache_store_core;
    import lfucs_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int COUNT_BITS  = 4;    // narrow counts so saturation shows up in a short run
    localparam int COUNT_TOP   = (1 << COUNT_BITS) - 1;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 128;
    localparam int SETTLE      = 4 * ENTRIES + 8;
    localparam int LONG_HOLD   = 300;
    localparam int LIMIT       = 500000;
    localparam int POOL        = 24;

    // Shadow copy of the store: predicts every get word and checks what comes out.
    class lfu_store_shadow;
        bit               used_slot[ENTRIES];
        logic [KEY_W-1:0] slot_key[ENTRIES];
        logic [KEY_W-1:0] slot_data[ENTRIES];
        int unsigned      slot_count[ENTRIES];
        int unsigned      slot_rank[ENTRIES];
        int unsigned      capacity;
        t_res             pending_reads[$];
        int               mismatches;

        function new();
            capacity = CAP_RESET;
            mismatches = 0;
            foreach (used_slot[i]) used_slot[i] = 1'b0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function int lookup(logic [KEY_W-1:0] key);
            for (int i = 0; i < ENTRIES; i++) begin
                if (used_slot[i] && slot_key[i] == key) return i;
            end
            return -1;
        endfunction

        // count up (saturating) and move to the front of the recency order
        function void promote(int s);
            int unsigned old_rank;
            old_rank = slot_rank[s];
            if (slot_count[s] < COUNT_TOP) slot_count[s]++;
            for (int j = 0; j < ENTRIES; j++) begin
                if (j != s && used_slot[j] && slot_rank[j] < old_rank) slot_rank[j]++;
            end
            slot_rank[s] = 0;
        endfunction

        function void take_word(logic mode, logic [KEY_W-1:0] key, logic [KEY_W-1:0] value);
            int          s;
            int          victim;
            int          free_slot;
            int unsigned limit;
            int unsigned occupied;
            int unsigned r;
            t_res        res;
            s = lookup(key);
            if (mode == MODE_GET) begin
                res.hit = (s >= 0);
                res.read_value = (s >= 0) ? slot_data[s] : MISS_VALUE;
                if (s >= 0) promote(s);
                pending_reads.insert(pending_reads.size(), res);
                return;
            end
            if (capacity == 0) return;
            if (s >= 0) begin
                slot_data[s] = value;
                promote(s);
                return;
            end
            limit = (capacity < ENTRIES) ? capacity : ENTRIES;
            occupied = 0;
            victim = -1;
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (used_slot[i]) begin
                    occupied++;
                    if (victim < 0 || slot_count[i] < slot_count[victim] ||
                        (slot_count[i] == slot_count[victim] &&
                         slot_rank[i] > slot_rank[victim]))
                        victim = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (occupied >= limit && victim >= 0) begin
                r = slot_rank[victim];
                used_slot[victim] = 1'b0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (used_slot[i] && slot_rank[i] > r) slot_rank[i]--;
                end
                free_slot = victim;
            end
            if (free_slot < 0) return;
            for (int i = 0; i < ENTRIES; i++) begin
                if (used_slot[i]) slot_rank[i]++;
            end
            used_slot[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_data[free_slot] = value;
            slot_count[free_slot] = 1;
            slot_rank[free_slot] = 0;
        endfunction

        function void match_result(logic hit, logic signed [KEY_W-1:0] rv);
            t_res want;
            if (pending_reads.size() == 0) begin
                mismatches++;
                $error("result word with nothing expected: hit %0b read_value %0h", hit, rv);
                return;
            end
            want = pending_reads.pop_front();
            if (hit !== want.hit) begin
                mismatches++;
                $error("hit: expected %0b, actual %0b", want.hit, hit);
            end
            if (rv !== want.read_value) begin
                mismatches++;
                $error("read_value: expected %0h, actual %0h", want.read_value, rv);
            end
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata = '0;
    logic                    i_valid     = 1'b0;
    logic                    i_mode      = MODE_GET;
    logic [KEY_W-1:0]        i_key       = '0;
    logic [KEY_W-1:0]        i_value     = '0;
    logic                    i_stall     = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic                    o_hit;
    logic signed [KEY_W-1:0] o_read_value;

    lfu_store_shadow shadow = new();
    bit tx_idle      = 1'b0;
    bit rx_idle      = 1'b0;
    bit hold_request = 1'b0;
    int cycles       = 0;

    lfu_cache_store_core #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("lfu_cache_store_core regression: fail");
            $finish;
        end
    end

    // Output side: check accepted words, stall in short bursts or one long hold.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
                shadow.match_result(o_hit, o_read_value);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
                hold_left = $urandom_range(1, 6);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [KEY_W-1:0] value);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        shadow.take_word(mode, key, value);
    endtask

    // sets return nothing, so give the engine time to finish after the last get drains
    task automatic quiesce();
        i_valid <= 1'b0;
        while (shadow.pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow.set_capacity(c);
    endtask

    initial begin
        logic [KEY_W-1:0] pool[POOL];
        logic [CAP_W-1:0] cap_plan[PHASES];
        logic             mode;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
        int               lim;
        int               span;
        bit               last;

        cap_plan = '{5'd31, 5'd4, 5'd0, 5'd1, 5'd16, 5'd2,
                     5'd17, 5'd8, 5'd0, 5'd12, 5'd5, 5'd16};
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7fff_ffff;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL; i++) pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extreme keys and values, update of a present key
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(MODE_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_word(MODE_GET, 32'h8000_0000, 32'hffff_ffff);
        send_word(MODE_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_word(MODE_GET, 32'h7fff_ffff, 32'h0000_0000);
        send_word(MODE_SET, 32'h0000_0000, 32'h0000_0000);
        send_word(MODE_SET, 32'hffff_ffff, 32'hffff_ffff);
        send_word(MODE_GET, 32'hffff_ffff, 32'h5555_5555);
        send_word(MODE_GET, 32'h0000_0001, 32'haaaa_aaaa);
        send_word(MODE_SET, 32'h0000_0000, 32'h1234_5678);
        send_word(MODE_GET, 32'h0000_0000, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            write_capacity(cap_plan[p]);
            last = (p == PHASES - 1);
            if (p == 4) hold_request = 1'b1;
            for (int i = 0; i < 3; i++) pool[$urandom_range(4, POOL - 1)] = $urandom;
            lim = (cap_plan[p] < ENTRIES) ? cap_plan[p] : ENTRIES;
            span = lim + 1 + $urandom_range(0, 4);
            if (cap_plan[p] == 0 || span > POOL) span = POOL;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 32 == 0) begin
                    tx_idle = !last && $urandom_range(0, 2) != 0;
                    rx_idle = !last && $urandom_range(0, 2) != 0;
                end
                mode = ($urandom_range(0, 99) < 40) ? MODE_SET : MODE_GET;
                if ($urandom_range(0, 99) < 8) key = $urandom;
                else key = pool[$urandom_range(0, span - 1)];
                case ($urandom_range(0, 15))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7fff_ffff;
                    2: value = 32'hffff_ffff;
                    3: value = 32'h0000_0000;
                    default: value = $urandom;
                endcase
                send_word(mode, key, value);
            end
        end

        quiesce();
        if (shadow.mismatches == 0 && shadow.pending_reads.size() == 0)
            $display("lfu_cache_store_core regression: pass");
        else
            $display("lfu_cache_store_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
hdl/lfucs_pkg.sv
hdl/lfucs_engine.sv
hdl/lfu_cache_store_core.sv
tb/tb_lfu_cache_store_core.sv
